### rtl/core/shelf_rectangle_packer_top_defines.svh
// assertion macros for the shelf packer
`ifndef SHELF_RECTANGLE_PACKER_TOP_DEFINES_SVH
`define SHELF_RECTANGLE_PACKER_TOP_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define SRP_ASSERT_IMP(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
// next-cycle implication checked outside reset
`define SRP_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
`endif

### rtl/core/srp_pkg.sv
// package for the shelf packer: states, status codes, controller/datapath structs
`timescale 1ns / 1ps
package srp_pkg;
    localparam int unsigned DIM_W = 13;
    localparam int unsigned IDX_W = 6;
    localparam int unsigned STS_W = 2;

    localparam logic [STS_W-1:0] ST_PLACED = 2'd0;
    localparam logic [STS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL   = 2'd2;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SORT_INIT,
        S_SORT_RD,
        S_SORT_WAIT,
        S_SORT_CMP,
        S_SORT_DONE,
        S_PLACE_RD,
        S_PLACE_WAIT,
        S_PLACE_DO,
        S_OUT_RD,
        S_OUT_WAIT,
        S_OUT_SEND
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic store;      // write incoming item into stores
        logic sort_init;  // i = 0
        logic sort_ld;    // load j = i, key = h[i]
        logic sort_rd;    // read order[j-1] then h[that]
        logic sort_shift; // order[j] = order[j-1], j--
        logic sort_put;   // order[j] = i, i++
        logic place_init;
        logic place_rd;   // read order[k], widths
        logic place_do;   // process rectangle
        logic out_init;
        logic out_rd;
        logic out_load;   // load output register
        logic clr_count;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic count_full;
        logic sort_done;   // i == n
        logic j_zero;
        logic less;        // h[order[j-1]] < key
        logic place_done;  // k == n
        logic out_done;    // index == n
        logic count_zero;
    } t_sts;
endpackage

### rtl/core/shelf_rectangle_packer_top.sv
// Shelf packer: loads up to MAX_RECTS rectangles one item per cycle; the item marked last
// starts an insertion sort by descending height (stable), then a shelf placement pass,
// then one result item per rectangle in load order. Sort work grows with the shifts for
// each rectangle (quadratic worst case); placement visits each rectangle once and output
// can be held by m_axis_tready. No input is taken until all results leave.
`timescale 1ns / 1ps
module shelf_rectangle_packer_top #(
    parameter int unsigned MAX_RECTS = 64,
    parameter int unsigned DIM_BITS  = 13
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // rect_width, rect_height
    input  logic [((2*DIM_BITS+7)/8)*8-1:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // rect_index, place_x, place_y, place_status
    output logic [((srp_pkg::IDX_W+2*DIM_BITS+srp_pkg::STS_W+7)/8)*8-1:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [DIM_BITS-1:0] i_cfg_data
);
    import srp_pkg::*;
    `include "shelf_rectangle_packer_top_defines.svh"

    localparam int unsigned OUT_W = ((IDX_W + 2*DIM_BITS + STS_W + 7) / 8) * 8;

    t_cmd cmd;
    t_sts sts;
    logic [DIM_BITS-1:0] r_atlas_w, r_atlas_h;
    logic [IDX_W-1:0]    idx;
    logic [DIM_BITS-1:0] px, py;
    logic [STS_W-1:0]    pst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_atlas_w <= DIM_BITS'(1024);
            r_atlas_h <= DIM_BITS'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_atlas_w <= i_cfg_data;
                CFG_HEIGHT: r_atlas_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    srp_ctrl u_ctrl (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .i_last(s_axis_tlast),
        .m_axis_tvalid, .m_axis_tready, .o_cmd(cmd), .i_sts(sts)
    );

    srp_dp #(.MAX_RECTS(MAX_RECTS), .DIM_BITS(DIM_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts),
        .i_w(s_axis_tdata[DIM_BITS-1:0]), .i_h(s_axis_tdata[2*DIM_BITS-1:DIM_BITS]),
        .i_atlas_w(r_atlas_w), .i_atlas_h(r_atlas_h),
        .o_index(idx), .o_x(px), .o_y(py), .o_status(pst), .o_last(m_axis_tlast)
    );

    // upper pad bits are zero
    assign m_axis_tdata = OUT_W'({pst, py, px, idx});

    `SRP_ASSERT_IMP(a_no_take_while_out, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "input taken while result pending")
    `SRP_ASSERT_IMP(a_status_code, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[6+2*DIM_BITS+1:6+2*DIM_BITS] != 2'd3, "bad status")
    `SRP_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
endmodule

### rtl/core/srp_ctrl.sv
// controller state machine for the shelf packer
`timescale 1ns / 1ps
module srp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic            i_last,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output srp_pkg::t_cmd   o_cmd,
    input  srp_pkg::t_sts   i_sts
);
    import srp_pkg::*;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign m_axis_tvalid = r_ovalid;

    always_comb begin
        n_state       = r_state;
        n_ovalid      = r_ovalid;
        o_cmd         = '0;
        s_axis_tready = 1'b0;
        if (m_axis_tready) n_ovalid = 1'b0;
        case (r_state)
            S_LOAD: begin
                // new items wait until the last result of the run has gone
                s_axis_tready = !r_ovalid;
                if (s_axis_tvalid && !r_ovalid) begin
                    o_cmd.store = !i_sts.count_full;
                    if (i_last) n_state = S_SORT_INIT;
                end
            end
            S_SORT_INIT: begin
                o_cmd.sort_init = 1'b1;
                n_state = S_SORT_DONE;
            end
            S_SORT_DONE: begin
                // start next insertion or go to placement
                if (i_sts.sort_done) begin
                    o_cmd.place_init = 1'b1;
                    n_state = S_PLACE_RD;
                end else begin
                    o_cmd.sort_ld = 1'b1;
                    n_state = S_SORT_RD;
                end
            end
            S_SORT_RD: begin
                if (i_sts.j_zero) begin
                    o_cmd.sort_put = 1'b1;
                    n_state = S_SORT_DONE;
                end else begin
                    o_cmd.sort_rd = 1'b1;
                    n_state = S_SORT_WAIT;
                end
            end
            S_SORT_WAIT: n_state = S_SORT_CMP;
            S_SORT_CMP: begin
                if (i_sts.less) begin
                    o_cmd.sort_shift = 1'b1;
                    n_state = S_SORT_RD;
                end else begin
                    o_cmd.sort_put = 1'b1;
                    n_state = S_SORT_DONE;
                end
            end
            S_PLACE_RD: begin
                if (i_sts.place_done) begin
                    o_cmd.out_init = 1'b1;
                    n_state = S_OUT_RD;
                end else begin
                    o_cmd.place_rd = 1'b1;
                    n_state = S_PLACE_WAIT;
                end
            end
            S_PLACE_WAIT: n_state = S_PLACE_DO;
            S_PLACE_DO: begin
                o_cmd.place_do = 1'b1;
                n_state = S_PLACE_RD;
            end
            S_OUT_RD: begin
                if (i_sts.out_done) begin
                    o_cmd.clr_count = 1'b1;
                    n_state = S_LOAD;
                end else begin
                    o_cmd.out_rd = 1'b1;
                    n_state = S_OUT_WAIT;
                end
            end
            S_OUT_WAIT: n_state = S_OUT_SEND;
            S_OUT_SEND: begin
                if (!r_ovalid || m_axis_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_ovalid = 1'b1;
                    n_state = S_OUT_RD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end
endmodule

### rtl/core/srp_dp.sv
// datapath for the shelf packer: stores, sort indices, shelf cursor, output register
`timescale 1ns / 1ps
module srp_dp #(
    parameter int unsigned MAX_RECTS = 64,
    parameter int unsigned DIM_BITS  = 13
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  srp_pkg::t_cmd              i_cmd,
    output srp_pkg::t_sts              o_sts,
    input  logic [DIM_BITS-1:0]        i_w,
    input  logic [DIM_BITS-1:0]        i_h,
    input  logic [DIM_BITS-1:0]        i_atlas_w,
    input  logic [DIM_BITS-1:0]        i_atlas_h,
    output logic [srp_pkg::IDX_W-1:0]  o_index,
    output logic [DIM_BITS-1:0]        o_x,
    output logic [DIM_BITS-1:0]        o_y,
    output logic [srp_pkg::STS_W-1:0]  o_status,
    output logic                       o_last
);
    import srp_pkg::*;

    localparam int unsigned AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int unsigned CW = $clog2(MAX_RECTS + 1);
    localparam int unsigned PW = 2 * DIM_BITS + STS_W;

    logic [DIM_BITS-1:0] m_w   [MAX_RECTS];
    logic [DIM_BITS-1:0] m_h   [MAX_RECTS];
    logic [DIM_BITS-1:0] m_h2  [MAX_RECTS];
    logic [AW-1:0]       m_ord [MAX_RECTS];
    logic [PW-1:0]       m_pos [MAX_RECTS];

    logic [CW-1:0]       r_count, r_i, r_j, r_k, r_o;
    logic [DIM_BITS-1:0] r_key;
    logic [AW-1:0]       r_ord_q;
    logic [DIM_BITS-1:0] r_hq, r_wq, r_h2q;
    logic [PW-1:0]       r_pos_q;
    logic [DIM_BITS:0]   r_cx, r_cy;
    logic [DIM_BITS-1:0] r_shelf;
    logic                r_stage;   // second read cycle of compare pipeline
    logic [AW-1:0]       r_pidx;

    // count write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= '0;
        else if (i_cmd.clr_count) r_count <= '0;
        else if (i_cmd.store) r_count <= r_count + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            m_w[r_count[AW-1:0]]  <= i_w;
            m_h[r_count[AW-1:0]]  <= i_h;
            m_h2[r_count[AW-1:0]] <= i_h;
        end
    end

    // order store: one write and one read port
    logic          ord_we;
    logic [AW-1:0] ord_wa, ord_wd, ord_ra;
    always_comb begin
        ord_we = i_cmd.sort_shift || i_cmd.sort_put;
        ord_wa = r_j[AW-1:0];
        ord_wd = i_cmd.sort_shift ? r_ord_q : r_i[AW-1:0];
        ord_ra = i_cmd.place_rd ? r_k[AW-1:0] : (r_j[AW-1:0] - 1'b1);
    end
    always_ff @(posedge i_clk) begin
        if (ord_we) m_ord[ord_wa] <= ord_wd;
        r_ord_q <= m_ord[ord_ra];
    end

    // second read of heights, addressed by order output
    always_ff @(posedge i_clk) begin
        r_h2q <= m_h2[r_ord_q];
        r_hq  <= m_h[r_stage ? r_ord_q : r_i[AW-1:0]];
        r_wq  <= m_w[r_ord_q];
    end

    // sort control registers: the compare uses h[order[j-1]] from r_ord_q, then r_h2q
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0; r_j <= '0; r_stage <= 1'b0;
        end else begin
            r_stage <= i_cmd.sort_rd || i_cmd.place_rd;
            if (i_cmd.sort_init) r_i <= '0;
            if (i_cmd.sort_ld) begin
                r_j <= r_i;
            end
            if (i_cmd.sort_shift) r_j <= r_j - 1'b1;
            if (i_cmd.sort_put) r_i <= r_i + 1'b1;
        end
    end

    // key: height of item i, read during sort_ld
    logic r_key_ld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_key_ld <= 1'b0;
        else r_key_ld <= i_cmd.sort_ld;
        if (r_key_ld) r_key <= r_hq;
    end

    always_comb begin
        o_sts.count_full = (r_count == CW'(MAX_RECTS));
        o_sts.sort_done  = (r_i == r_count);
        o_sts.j_zero     = (r_j == '0);
        o_sts.less       = (r_h2q < r_key);
        o_sts.place_done = (r_k == r_count);
        o_sts.out_done   = (r_o == r_count);
        o_sts.count_zero = (r_count == '0);
    end

    // placement
    logic [DIM_BITS:0]   cx1, cy1;
    logic [DIM_BITS-1:0] sh1;
    logic                wrap, full, empty;
    logic [PW-1:0]       pos_new;
    always_comb begin
        empty = (r_wq == '0) || (r_h2q == '0);
        wrap  = ({1'b0, r_wq} + r_cx) > {1'b0, i_atlas_w};
        cx1   = wrap ? '0 : r_cx;
        cy1   = wrap ? (r_cy + {1'b0, r_shelf}) : r_cy;
        sh1   = wrap ? '0 : r_shelf;
        full  = ({1'b0, r_h2q} + cy1) > {1'b0, i_atlas_h};
        if (empty)     pos_new = {ST_EMPTY, {(2*DIM_BITS){1'b0}}};
        else if (full) pos_new = {ST_FULL, {(2*DIM_BITS){1'b0}}};
        else pos_new = {ST_PLACED, cy1[DIM_BITS-1:0], cx1[DIM_BITS-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0; r_cx <= '0; r_cy <= '0; r_shelf <= '0;
        end else if (i_cmd.place_init) begin
            r_k <= '0; r_cx <= '0; r_cy <= '0; r_shelf <= '0;
        end else begin
            if (i_cmd.place_rd) r_k <= r_k + 1'b1;
            if (i_cmd.place_do && !empty) begin
                r_cy <= cy1;
                if (full) begin
                    r_cx <= cx1; r_shelf <= sh1;
                end else begin
                    r_cx <= cx1 + {1'b0, r_wq};
                    r_shelf <= (r_h2q > sh1) ? r_h2q : sh1;
                end
            end
        end
    end

    // index of the rectangle being placed, taken from the order read output in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (r_stage) r_pidx <= r_ord_q;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.place_do) m_pos[r_pidx] <= pos_new;
        r_pos_q <= m_pos[r_o[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o <= '0;
        else if (i_cmd.out_init) r_o <= '0;
        else if (i_cmd.out_load) r_o <= r_o + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_index  <= IDX_W'(r_o);
            o_x      <= r_pos_q[DIM_BITS-1:0];
            o_y      <= r_pos_q[2*DIM_BITS-1:DIM_BITS];
            o_status <= r_pos_q[PW-1:2*DIM_BITS];
            o_last   <= (r_o + 1'b1 == r_count);
        end
    end
endmodule

### tb/tb_shelf_rectangle_packer_top.sv
// testbench for the shelf packer: directed and random rectangle sets checked against a shelf placement predictor
`timescale 1ns / 1ps
module tb_shelf_rectangle_packer_top;
    import srp_pkg::*;

    localparam int MAX_R = 64;
    localparam int LIMIT = 3000000;

    typedef struct packed {
        logic [5:0]  idx;
        logic [12:0] x;
        logic [12:0] y;
        logic [1:0]  sts;
        logic        last;
    } t_place;

    class placement_board;
        logic [12:0] widths[$];
        logic [12:0] heights[$];
        logic [12:0] atlas_w = 1024;
        logic [12:0] atlas_h = 1024;
        t_place      pending[$];
        int          errors = 0;

        // store the rectangle while fewer than MAX_R are held and pack the whole set on the last one
        function void note_rect(logic [12:0] w, logic [12:0] h, logic last);
            int          n;
            int          ord[$];
            int          j;
            int          ri;
            logic [13:0] cx;
            logic [13:0] cy;
            logic [12:0] sh;
            t_place      res[MAX_R];
            if (widths.size() < MAX_R) begin
                widths.push_back(w);
                heights.push_back(h);
            end
            if (!last) return;
            n = widths.size();
            for (int i = 0; i < n; i++) begin
                j = 0;
                while (j < ord.size() && heights[ord[j]] >= heights[i]) j++;
                ord.insert(j, i);
            end
            cx = 0;
            cy = 0;
            sh = 0;
            for (int k = 0; k < n; k++) begin
                ri = ord[k];
                res[ri] = '{idx: ri[5:0], x: 0, y: 0, sts: ST_PLACED, last: ri == n - 1};
                if (widths[ri] == 0 || heights[ri] == 0) begin
                    res[ri].sts = ST_EMPTY;
                    continue;
                end
                if (cx + widths[ri] > atlas_w) begin
                    cy = cy + sh;
                    cx = 0;
                    sh = 0;
                end
                if (cy + heights[ri] > atlas_h) begin
                    res[ri].sts = ST_FULL;
                    continue;
                end
                res[ri].x = cx[12:0];
                res[ri].y = cy[12:0];
                cx = cx + widths[ri];
                if (heights[ri] > sh) sh = heights[ri];
            end
            for (int i = 0; i < n; i++) pending.push_back(res[i]);
            widths.delete();
            heights.delete();
        endfunction

        function void check_place(t_place got);
            t_place exp_p;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", got);
                return;
            end
            exp_p = pending.pop_front();
            if (got !== exp_p) begin
                errors++;
                if (errors <= 10) $display("mismatch: expected %p got %p", exp_p, got);
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = 0;
    logic        s_axis_tlast = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_we = 0;
    logic        i_cfg_index = CFG_WIDTH;
    logic [12:0] i_cfg_data = 0;

    placement_board board = new();
    int send_idle = 0;
    int recv_stall = 0;
    int cycles = 0;

    shelf_rectangle_packer_top u_top (.*);

    always begin
        #4 i_clk = 1;
        #4 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_place({m_axis_tdata[5:0], m_axis_tdata[18:6], m_axis_tdata[31:19],
                               m_axis_tdata[33:32], m_axis_tlast});
    end

    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall);

    // valid stays high after the item unless an idle gap or a drain follows
    task automatic send_rect(logic [12:0] w, logic [12:0] h, logic last);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {6'd0, h, w};
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_rect(w, h, last);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_atlas(logic [12:0] w, logic [12:0] h);
        i_cfg_we    <= 1;
        i_cfg_index <= CFG_WIDTH;
        i_cfg_data  <= w;
        @(negedge i_clk);
        i_cfg_index <= CFG_HEIGHT;
        i_cfg_data  <= h;
        @(negedge i_clk);
        i_cfg_we <= 0;
        board.atlas_w = w;
        board.atlas_h = h;
    endtask

    function automatic logic [12:0] rand_dim();
        case ($urandom_range(9))
            0: return 0;
            1: return 13'd4096;
            2: return 13'($urandom_range(8191));
            3, 4: return 13'($urandom_range(1, 1024));
            default: return 13'($urandom_range(1, 300));
        endcase
    endfunction

    task automatic random_sets(int count);
        int n;
        while (count > 0) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
            for (int i = 0; i < n; i++) send_rect(rand_dim(), rand_dim(), i == n - 1);
            count -= n;
        end
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // zero sizes, extremes, equal heights, overflow of row and atlas
        send_rect(0, 50, 0);
        send_rect(50, 0, 0);
        send_rect(600, 100, 0);
        send_rect(600, 100, 0);
        send_rect(8191, 8191, 0);
        send_rect(4096, 4096, 0);
        send_rect(1, 1, 0);
        send_rect(424, 200, 1);
        send_rect(1024, 1024, 1);
        drain();
        write_atlas(1, 1);
        send_rect(1, 1, 0);
        send_rect(1, 1, 0);
        send_rect(2, 1, 1);
        drain();
        write_atlas(8191, 8191);
        for (int i = 0; i < 66; i++) send_rect(13'($urandom_range(1, 300)), 13'(i % 5), i == 65);
        drain();
        write_atlas(4096, 4096);
        random_sets(45);
        drain();
        send_idle = 88;
        write_atlas(500, 300);
        random_sets(45);
        drain();
        send_idle = 0;
        recv_stall = 88;
        write_atlas(1024, 1024);
        random_sets(45);
        drain();
        send_idle = 19;
        recv_stall = 19;
        write_atlas(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)));
        random_sets(45);
        drain();
        if (board.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

### files.f
+incdir+rtl/core
rtl/core/srp_pkg.sv
rtl/core/srp_ctrl.sv
rtl/core/srp_dp.sv
rtl/core/shelf_rectangle_packer_top.sv
tb/tb_shelf_rectangle_packer_top.sv
